// ----- hdl/rgbycc_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgbycc_pkg
// Shared types and BT.601 full-range coefficients for the 2x2 block
// RGB to YCbCr 4:2:0 converter.
// ---------------------------------------------------------------------------
package rgbycc_pkg;

   localparam int unsigned PIX_WIDTH    = 8;
   localparam int unsigned LANE_COUNT   = 4;
   localparam int unsigned FIX_SHIFT    = 10;
   localparam int unsigned ACC_WIDTH    = PIX_WIDTH + FIX_SHIFT;
   localparam int unsigned SUM_WIDTH    = PIX_WIDTH + 2;

   // coefficient magnitudes, scaled by 1024
   localparam int unsigned COEF_Y_R     = 306;
   localparam int unsigned COEF_Y_G     = 601;
   localparam int unsigned COEF_Y_B     = 117;
   localparam int unsigned COEF_CB_R    = 173;
   localparam int unsigned COEF_CB_G    = 339;
   localparam int unsigned COEF_CB_B    = 512;
   localparam int unsigned COEF_CR_R    = 512;
   localparam int unsigned COEF_CR_G    = 429;
   localparam int unsigned COEF_CR_B    = 83;
   localparam int unsigned CHROMA_BIAS  = 128 << FIX_SHIFT;
   localparam int unsigned ROUND_BIAS   = 2;

   // configuration port
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam logic [0:0]  REG_CHANNEL_ORDER = 1'b0;

   typedef enum logic {
      ORDER_RGB = 1'b0,
      ORDER_BGR = 1'b1
   } channel_order_type;

   typedef struct packed {
      logic [PIX_WIDTH-1:0] byte0;
      logic [PIX_WIDTH-1:0] byte1;
      logic [PIX_WIDTH-1:0] byte2;
   } pixel_type;

   typedef struct packed {
      logic [PIX_WIDTH-1:0] luma;
      logic [PIX_WIDTH-1:0] cb;
      logic [PIX_WIDTH-1:0] cr;
   } lane_result_type;

   typedef struct packed {
      logic [PIX_WIDTH-1:0] luma_top_left;
      logic [PIX_WIDTH-1:0] luma_top_right;
      logic [PIX_WIDTH-1:0] luma_bottom_left;
      logic [PIX_WIDTH-1:0] luma_bottom_right;
      logic [PIX_WIDTH-1:0] chroma_blue;
      logic [PIX_WIDTH-1:0] chroma_red;
   } block_result_type;

endpackage

// ----- hdl/rgbycc_lane.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgbycc_lane
// Per-pixel colour conversion: selects R/B by channel order, forms Y, Cb
// and Cr in fixed point and registers them.
// ---------------------------------------------------------------------------
module rgbycc_lane (
   input  logic                        clock,
   input  logic                        enable,
   input  rgbycc_pkg::channel_order_type order,
   input  rgbycc_pkg::pixel_type       pixel,
   output rgbycc_pkg::lane_result_type result
);
   import rgbycc_pkg::*;

   logic [PIX_WIDTH-1:0] red;
   logic [PIX_WIDTH-1:0] green;
   logic [PIX_WIDTH-1:0] blue;
   logic [ACC_WIDTH-1:0] y_acc;
   logic [ACC_WIDTH-1:0] cb_acc;
   logic [ACC_WIDTH-1:0] cr_acc;
   lane_result_type      result_ff;
   lane_result_type      result_in;

   always_comb begin
      green = pixel.byte1;
      unique case (order)
         ORDER_RGB: begin
            red  = pixel.byte0;
            blue = pixel.byte2;
         end
         ORDER_BGR: begin
            red  = pixel.byte2;
            blue = pixel.byte0;
         end
         default: begin
            red  = pixel.byte0;
            blue = pixel.byte2;
         end
      endcase
   end

   // biased chroma sums are never negative; modulo arithmetic keeps them exact
   assign y_acc  = ACC_WIDTH'(COEF_Y_R * red + COEF_Y_G * green + COEF_Y_B * blue);
   assign cb_acc = ACC_WIDTH'(CHROMA_BIAS + COEF_CB_B * blue
                              - COEF_CB_R * red - COEF_CB_G * green);
   assign cr_acc = ACC_WIDTH'(CHROMA_BIAS + COEF_CR_R * red
                              - COEF_CR_G * green - COEF_CR_B * blue);

   always_comb begin
      result_in.luma = y_acc[ACC_WIDTH-1:FIX_SHIFT];
      result_in.cb   = cb_acc[ACC_WIDTH-1:FIX_SHIFT];
      result_in.cr   = cr_acc[ACC_WIDTH-1:FIX_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ----- hdl/rgbycc_merge.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgbycc_merge
// Combines the four lane results: passes luma through and forms the
// rounded mean of the block chroma, into the output register.
// ---------------------------------------------------------------------------
module rgbycc_merge (
   input  logic                          clock,
   input  logic                          enable,
   input  rgbycc_pkg::lane_result_type   lanes [rgbycc_pkg::LANE_COUNT],
   output rgbycc_pkg::block_result_type  result
);
   import rgbycc_pkg::*;

   logic [SUM_WIDTH-1:0] cb_sum;
   logic [SUM_WIDTH-1:0] cr_sum;
   block_result_type     result_ff;
   block_result_type     result_in;

   assign cb_sum = SUM_WIDTH'(lanes[0].cb) + SUM_WIDTH'(lanes[1].cb)
                 + SUM_WIDTH'(lanes[2].cb) + SUM_WIDTH'(lanes[3].cb)
                 + SUM_WIDTH'(ROUND_BIAS);
   assign cr_sum = SUM_WIDTH'(lanes[0].cr) + SUM_WIDTH'(lanes[1].cr)
                 + SUM_WIDTH'(lanes[2].cr) + SUM_WIDTH'(lanes[3].cr)
                 + SUM_WIDTH'(ROUND_BIAS);

   always_comb begin
      result_in.luma_top_left     = lanes[0].luma;
      result_in.luma_top_right    = lanes[1].luma;
      result_in.luma_bottom_left  = lanes[2].luma;
      result_in.luma_bottom_right = lanes[3].luma;
      result_in.chroma_blue       = cb_sum[SUM_WIDTH-1:2];
      result_in.chroma_red        = cr_sum[SUM_WIDTH-1:2];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ----- hdl/rgb_block_to_ycbcr420_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_block_to_ycbcr420_top
// 2x2 block RGB/BGR to BT.601 full-range YCbCr 4:2:0 converter.
//
//   channel  direction  handshake                contents
//   req_     in         req_valid / req_ready    four pixels, three bytes each
//   rsp_     out        rsp_valid / rsp_ready    four luma, one Cb, one Cr
//   csr_     in/out     APB, pready tied high    channel_order at address 0
//
// One block per cycle while the output is not stalled; a block passes the lane
// register, then the output register after the chroma merge.
// Synchronous reset empties both stages and sets channel order to RGB.
// A stalled output holds the output stage and a full lane stage; req_ready drops only while both are full.
// ---------------------------------------------------------------------------
module rgb_block_to_ycbcr420_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [rgbycc_pkg::PIX_WIDTH-1:0]     req_top_left_byte0,
   input  logic [rgbycc_pkg::PIX_WIDTH-1:0]     req_top_left_byte1,
   input  logic [rgbycc_pkg::PIX_WIDTH-1:0]     req_top_left_byte2,
   input  logic [rgbycc_pkg::PIX_WIDTH-1:0]     req_top_right_byte0,
   input  logic [rgbycc_pkg::PIX_WIDTH-1:0]     req_top_right_byte1,
   input  logic [rgbycc_pkg::PIX_WIDTH-1:0]     req_top_right_byte2,
   input  logic [rgbycc_pkg::PIX_WIDTH-1:0]     req_bottom_left_byte0,
   input  logic [rgbycc_pkg::PIX_WIDTH-1:0]     req_bottom_left_byte1,
   input  logic [rgbycc_pkg::PIX_WIDTH-1:0]     req_bottom_left_byte2,
   input  logic [rgbycc_pkg::PIX_WIDTH-1:0]     req_bottom_right_byte0,
   input  logic [rgbycc_pkg::PIX_WIDTH-1:0]     req_bottom_right_byte1,
   input  logic [rgbycc_pkg::PIX_WIDTH-1:0]     req_bottom_right_byte2,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [rgbycc_pkg::PIX_WIDTH-1:0]     rsp_luma_top_left,
   output logic [rgbycc_pkg::PIX_WIDTH-1:0]     rsp_luma_top_right,
   output logic [rgbycc_pkg::PIX_WIDTH-1:0]     rsp_luma_bottom_left,
   output logic [rgbycc_pkg::PIX_WIDTH-1:0]     rsp_luma_bottom_right,
   output logic [rgbycc_pkg::PIX_WIDTH-1:0]     rsp_chroma_blue,
   output logic [rgbycc_pkg::PIX_WIDTH-1:0]     rsp_chroma_red,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rgbycc_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [rgbycc_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [rgbycc_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                 csr_pready
);
   import rgbycc_pkg::*;

   channel_order_type order_ff;
   channel_order_type order_in;
   logic              lane_valid_ff;
   logic              lane_valid_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic              lane_enable;
   logic              out_enable;
   logic              csr_write;
   logic              csr_hit;
   pixel_type         pixels  [LANE_COUNT];
   lane_result_type   lane_results [LANE_COUNT];
   block_result_type  block_result;

   // ---- configuration ----
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_WIDTH-1] == REG_CHANNEL_ORDER);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      order_in = order_ff;
      if (csr_write && csr_hit) begin
         order_in = channel_order_type'(csr_pwdata[0]);
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_hit) begin
         csr_prdata[0] = order_ff;
      end
   end

   // ---- pipeline control ----
   assign out_enable    = ~out_valid_ff | rsp_ready;
   assign lane_enable   = ~lane_valid_ff | out_enable;
   assign req_ready     = lane_enable;
   assign lane_valid_in = lane_enable ? req_valid : lane_valid_ff;
   assign out_valid_in  = out_enable ? lane_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff      <= ORDER_RGB;
         lane_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         order_ff      <= order_in;
         lane_valid_ff <= lane_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // ---- lanes ----
   assign pixels[0] = '{req_top_left_byte0, req_top_left_byte1, req_top_left_byte2};
   assign pixels[1] = '{req_top_right_byte0, req_top_right_byte1, req_top_right_byte2};
   assign pixels[2] = '{req_bottom_left_byte0, req_bottom_left_byte1,
                        req_bottom_left_byte2};
   assign pixels[3] = '{req_bottom_right_byte0, req_bottom_right_byte1,
                        req_bottom_right_byte2};

   for (genvar i = 0; i < LANE_COUNT; i++) begin : g_lane
      rgbycc_lane u_lane (
         .clock  (clock),
         .enable (lane_enable),
         .order  (order_ff),
         .pixel  (pixels[i]),
         .result (lane_results[i])
      );
   end

   rgbycc_merge u_merge (
      .clock  (clock),
      .enable (out_enable),
      .lanes  (lane_results),
      .result (block_result)
   );

   assign rsp_valid             = out_valid_ff;
   assign rsp_luma_top_left     = block_result.luma_top_left;
   assign rsp_luma_top_right    = block_result.luma_top_right;
   assign rsp_luma_bottom_left  = block_result.luma_bottom_left;
   assign rsp_luma_bottom_right = block_result.luma_bottom_right;
   assign rsp_chroma_blue       = block_result.chroma_blue;
   assign rsp_chroma_red        = block_result.chroma_red;

endmodule

// ----- hdl/rgbycc_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgbycc_checker
// Port-level checks for the block converter, bound to the top level.
// ---------------------------------------------------------------------------
module rgbycc_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [rgbycc_pkg::PIX_WIDTH-1:0] rsp_luma_top_left,
   input  logic [rgbycc_pkg::PIX_WIDTH-1:0] rsp_chroma_blue,
   input  logic [rgbycc_pkg::PIX_WIDTH-1:0] rsp_chroma_red,
   input  logic                             csr_pready
);
   import rgbycc_pkg::*;

   // stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_luma_top_left)
         && $stable(rsp_chroma_blue) && $stable(rsp_chroma_red))
      else $error("stalled response changed");

   // an empty output register never blocks the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // an accepted block moves from the lane register to the output register when the output moves
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 (rsp_ready || !rsp_valid) |=> rsp_valid)
      else $error("accepted transaction did not arrive");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");

endmodule

bind rgb_block_to_ycbcr420_top rgbycc_checker u_checker (.*);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the 2x2 block RGB/BGR to YCbCr 4:2:0 converter.
// Drives pixel blocks through the req_ handshake and programs the channel
// order over the APB port. A scoreboard predicts each block's luma and
// averaged chroma and checks every rsp_ transaction in order. Both sides
// insert random gaps, and one phase holds the output off for a long stretch.
// ---------------------------------------------------------------------------
module tb;
   import rgbycc_pkg::*;

   typedef pixel_type [LANE_COUNT-1:0] quad_type;

   localparam int K_Y_R  = COEF_Y_R;
   localparam int K_Y_G  = COEF_Y_G;
   localparam int K_Y_B  = COEF_Y_B;
   localparam int K_CB_R = COEF_CB_R;
   localparam int K_CB_G = COEF_CB_G;
   localparam int K_CB_B = COEF_CB_B;
   localparam int K_CR_R = COEF_CR_R;
   localparam int K_CR_G = COEF_CR_G;
   localparam int K_CR_B = COEF_CR_B;
   localparam int C_BIAS = CHROMA_BIAS;
   localparam int R_BIAS = ROUND_BIAS;

   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_ORDER = CSR_ADDR_WIDTH'(4 * REG_CHANNEL_ORDER);
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_SPARE =
      CSR_ADDR_WIDTH'(4 * (REG_CHANNEL_ORDER + 1));

   localparam int DIRECTED_PATTERNS = 10;
   localparam int RANDOM_BLOCKS     = 950;
   localparam int PHASES            = 6;
   localparam int NO_IDLE_PHASE     = 2;
   localparam int HOLD_PHASE        = 3;
   localparam int HOLD_CYCLES       = 300;
   localparam int DRAIN_CYCLES      = 8;

   class ycc_scoreboard;
      channel_order_type order;
      block_result_type  due[$];
      int                errors;

      function new();
         order  = ORDER_RGB;
         errors = 0;
      endfunction

      function int clip8(int v);
         if (v < 0) return 0;
         if (v > 255) return 255;
         return v;
      endfunction

      function block_result_type convert(quad_type q);
         int r, g, b;
         int luma[LANE_COUNT];
         int sum_cb, sum_cr;
         block_result_type res;
         sum_cb = 0;
         sum_cr = 0;
         for (int p = 0; p < LANE_COUNT; p++) begin
            g = q[p].byte1;
            r = (order == ORDER_BGR) ? q[p].byte2 : q[p].byte0;
            b = (order == ORDER_BGR) ? q[p].byte0 : q[p].byte2;
            luma[p] = clip8((K_Y_R * r + K_Y_G * g + K_Y_B * b) >>> FIX_SHIFT);
            sum_cb += (-K_CB_R * r - K_CB_G * g + K_CB_B * b + C_BIAS) >>> FIX_SHIFT;
            sum_cr += (K_CR_R * r - K_CR_G * g - K_CR_B * b + C_BIAS) >>> FIX_SHIFT;
         end
         res.luma_top_left     = 8'(luma[0]);
         res.luma_top_right    = 8'(luma[1]);
         res.luma_bottom_left  = 8'(luma[2]);
         res.luma_bottom_right = 8'(luma[3]);
         res.chroma_blue       = 8'(clip8((sum_cb + R_BIAS) >>> 2));
         res.chroma_red        = 8'(clip8((sum_cr + R_BIAS) >>> 2));
         return res;
      endfunction

      function void note_block(quad_type q);
         due.push_back(convert(q));
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(block_result_type got);
         block_result_type want;
         if (due.size() == 0) begin
            $display("%0t: unexpected transaction, expected none actual %h", $time, got);
            errors++;
            return;
         end
         want = due.pop_front();
         compare_field("luma_top_left", want.luma_top_left, got.luma_top_left);
         compare_field("luma_top_right", want.luma_top_right, got.luma_top_right);
         compare_field("luma_bottom_left", want.luma_bottom_left, got.luma_bottom_left);
         compare_field("luma_bottom_right", want.luma_bottom_right, got.luma_bottom_right);
         compare_field("chroma_blue", want.chroma_blue, got.chroma_blue);
         compare_field("chroma_red", want.chroma_red, got.chroma_red);
      endfunction

      function int pending();
         return due.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [PIX_WIDTH-1:0] req_top_left_byte0 = '0;
   logic [PIX_WIDTH-1:0] req_top_left_byte1 = '0;
   logic [PIX_WIDTH-1:0] req_top_left_byte2 = '0;
   logic [PIX_WIDTH-1:0] req_top_right_byte0 = '0;
   logic [PIX_WIDTH-1:0] req_top_right_byte1 = '0;
   logic [PIX_WIDTH-1:0] req_top_right_byte2 = '0;
   logic [PIX_WIDTH-1:0] req_bottom_left_byte0 = '0;
   logic [PIX_WIDTH-1:0] req_bottom_left_byte1 = '0;
   logic [PIX_WIDTH-1:0] req_bottom_left_byte2 = '0;
   logic [PIX_WIDTH-1:0] req_bottom_right_byte0 = '0;
   logic [PIX_WIDTH-1:0] req_bottom_right_byte1 = '0;
   logic [PIX_WIDTH-1:0] req_bottom_right_byte2 = '0;

   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [PIX_WIDTH-1:0] rsp_luma_top_left;
   logic [PIX_WIDTH-1:0] rsp_luma_top_right;
   logic [PIX_WIDTH-1:0] rsp_luma_bottom_left;
   logic [PIX_WIDTH-1:0] rsp_luma_bottom_right;
   logic [PIX_WIDTH-1:0] rsp_chroma_blue;
   logic [PIX_WIDTH-1:0] rsp_chroma_red;

   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   bit idle_on      = 1'b1;
   bit hold_request = 1'b0;

   ycc_scoreboard sb = new();

   rgb_block_to_ycbcr420_top u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_top_left_byte0     (req_top_left_byte0),
      .req_top_left_byte1     (req_top_left_byte1),
      .req_top_left_byte2     (req_top_left_byte2),
      .req_top_right_byte0    (req_top_right_byte0),
      .req_top_right_byte1    (req_top_right_byte1),
      .req_top_right_byte2    (req_top_right_byte2),
      .req_bottom_left_byte0  (req_bottom_left_byte0),
      .req_bottom_left_byte1  (req_bottom_left_byte1),
      .req_bottom_left_byte2  (req_bottom_left_byte2),
      .req_bottom_right_byte0 (req_bottom_right_byte0),
      .req_bottom_right_byte1 (req_bottom_right_byte1),
      .req_bottom_right_byte2 (req_bottom_right_byte2),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_luma_top_left      (rsp_luma_top_left),
      .rsp_luma_top_right     (rsp_luma_top_right),
      .rsp_luma_bottom_left   (rsp_luma_bottom_left),
      .rsp_luma_bottom_right  (rsp_luma_bottom_right),
      .rsp_chroma_blue        (rsp_chroma_blue),
      .rsp_chroma_red         (rsp_chroma_red),
      .csr_psel               (csr_psel),
      .csr_penable            (csr_penable),
      .csr_pwrite             (csr_pwrite),
      .csr_paddr              (csr_paddr),
      .csr_pwdata             (csr_pwdata),
      .csr_prdata             (csr_prdata),
      .csr_pready             (csr_pready)
   );

   always #1 clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      if (!idle_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] random_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic quad_type random_block();
      quad_type q;
      for (int p = 0; p < LANE_COUNT; p++) begin
         q[p] = {random_byte(), random_byte(), random_byte()};
         if ($urandom_range(0, 9) == 0)
            q[p].byte1 = q[p].byte0;
         if ($urandom_range(0, 9) == 0)
            q[p] = {3{q[p].byte0}};
      end
      return q;
   endfunction

   // flat colours, primaries, checkerboard and a mixed block
   function automatic quad_type directed_block(int k);
      pixel_type black, white;
      black = '0;
      white = '1;
      case (k)
         0:       return {4{black}};
         1:       return {4{white}};
         2:       return {4{pixel_type'({8'hFF, 8'h00, 8'h00})}};
         3:       return {4{pixel_type'({8'h00, 8'hFF, 8'h00})}};
         4:       return {4{pixel_type'({8'h00, 8'h00, 8'hFF})}};
         5:       return {4{pixel_type'({8'hFF, 8'h00, 8'hFF})}};
         6:       return {4{pixel_type'({8'h80, 8'h80, 8'h80})}};
         7:       return {4{pixel_type'({8'h00, 8'hFF, 8'hFF})}};
         8:       return {white, black, black, white};
         default: return {pixel_type'({8'h80, 8'h80, 8'h80}),
                          pixel_type'({8'h00, 8'h00, 8'hFF}),
                          pixel_type'({8'h00, 8'hFF, 8'h00}),
                          pixel_type'({8'hFF, 8'h00, 8'h00})};
      endcase
   endfunction

   task automatic send_block(input quad_type q);
      int gap;
      req_valid              <= 1'b1;
      req_top_left_byte0     <= q[0].byte0;
      req_top_left_byte1     <= q[0].byte1;
      req_top_left_byte2     <= q[0].byte2;
      req_top_right_byte0    <= q[1].byte0;
      req_top_right_byte1    <= q[1].byte1;
      req_top_right_byte2    <= q[1].byte2;
      req_bottom_left_byte0  <= q[2].byte0;
      req_bottom_left_byte1  <= q[2].byte1;
      req_bottom_left_byte2  <= q[2].byte2;
      req_bottom_right_byte0 <= q[3].byte0;
      req_bottom_right_byte1 <= q[3].byte1;
      req_bottom_right_byte2 <= q[3].byte2;
      do @(posedge clock); while (!req_ready);
      sb.note_block(q);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_WIDTH-1:0] addr,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_ORDER)
         sb.order = channel_order_type'(data[0]);
   endtask

   task automatic csr_check_order();
      logic [CSR_DATA_WIDTH-1:0] want;
      logic [CSR_DATA_WIDTH-1:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_ORDER;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      want = CSR_DATA_WIDTH'(sb.order);
      if (got !== want) begin
         $display("%0t: channel_order readback expected %0h actual %0h", $time, want, got);
         sb.errors++;
      end
   endtask

   // response side: random back-pressure plus one long hold-off on request
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_result({rsp_luma_top_left, rsp_luma_top_right, rsp_luma_bottom_left,
                             rsp_luma_bottom_right, rsp_chroma_blue, rsp_chroma_red});
         if (hold_request) begin
            hold_request = 1'b0;
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            stall = pick_gap();
            rsp_ready <= (stall == 0);
            if (stall > 0) stall--;
         end
      end
   end

   initial begin
      logic [CSR_DATA_WIDTH-1:0] word;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      csr_check_order();

      for (int k = 0; k < DIRECTED_PATTERNS; k++) send_block(directed_block(k));
      drain();
      csr_write(ADDR_ORDER, 32'hFFFF_FFFF);
      csr_check_order();
      for (int k = 0; k < DIRECTED_PATTERNS; k++) send_block(directed_block(k));
      drain();
      // unmapped register: write must have no effect
      csr_write(ADDR_SPARE, 32'h0000_0000);
      csr_check_order();

      for (int ph = 0; ph < PHASES; ph++) begin
         idle_on = (ph != NO_IDLE_PHASE) && (ph != HOLD_PHASE);
         word = $urandom();
         if (ph == 0) word[0] = ORDER_RGB;
         if (ph == 1) word[0] = ORDER_BGR;
         csr_write(ADDR_ORDER, word);
         csr_check_order();
         if (ph == HOLD_PHASE) hold_request = 1'b1;
         for (int n = 0; n < RANDOM_BLOCKS / PHASES; n++) send_block(random_block());
         drain();
      end

      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
